@@ rtl/core/uvs_pkg.sv @@
`default_nettype none
package uvs_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 16;

  localparam int unsigned SIN_A = 51472;
  localparam int unsigned SIN_B = 21024;
  localparam int unsigned SIN_C = 2320;

  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z = 3'd2;
  localparam logic [2:0] CFG_RADIUS_X = 3'd3;
  localparam logic [2:0] CFG_RADIUS_Y = 3'd4;
  localparam logic [2:0] CFG_RADIUS_Z = 3'd5;
  localparam logic [2:0] CFG_SEGMENTS = 3'd6;
  localparam logic [2:0] CFG_RINGS    = 3'd7;

  localparam logic OP_GRID = 1'b0;
  localparam logic OP_CAP  = 1'b1;
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] ring;
    logic [7:0] segment;
  } in_req_t;

  typedef struct packed {
    logic              kind;
    logic [16:0]       slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]       corner_a;
    logic [15:0]       corner_b;
    logic [15:0]       corner_c;
    logic              last;
  } out_req_t;

  // Record queued for emission, one per cell slot
  typedef struct packed {
    logic     vld;
    out_req_t rec;
  } slot_t;

endpackage
`default_nettype wire

@@ rtl/core/uvs_sin.sv @@
`default_nettype none
// Pipelined quarter-wave polynomial sine, 4 register stages
module uvs_sin
  import uvs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [ANGLE_BITS-1:0] ph,
  output logic signed [16:0]         s
);
  logic [1:0]  quad;
  logic [15:0] x_c;
  logic [ANGLE_BITS-3:0] frac;
  logic [ANGLE_BITS+12:0] fx;
  logic [15:0] x1_r, x2_r, x3_r, x4_r, x2v_r, x2v3_r;
  logic [1:0]  q1_r, q2_r, q3_r, q4_r;
  logic [15:0] t1_r, t2_r;
  logic [31:0] m1;
  logic [32:0] m2, m3;
  logic [16:0] tb;
  logic [15:0] ta;
  logic [15:0] sm;

  always_comb begin
    quad = ph[ANGLE_BITS-1 -: 2];
    frac = ph[ANGLE_BITS-3:0];
    fx = {frac, 15'd0};
    x_c = 16'(fx >> (ANGLE_BITS - 2));
    if (quad[0]) x_c = 16'd32768 - x_c;
  end

  assign m1 = 32'(x1_r) * 32'(x1_r);
  always_ff @(posedge clk) begin
    x1_r <= x_c;  q1_r <= quad;
    x2_r <= x1_r; q2_r <= q1_r; x2v_r <= 16'(m1 >> 15);
    x3_r <= x2_r; q3_r <= q2_r; x2v3_r <= x2v_r;
    t1_r <= 16'((32'(SIN_C) * 32'(x2v_r)) >> 15);
    x4_r <= x3_r; q4_r <= q3_r;
    t2_r <= 16'(m2 >> 15);
  end
  assign tb = 17'(SIN_B) - 17'(t1_r);
  assign m2 = 33'(tb) * 33'(x2v3_r);
  assign ta = 16'(SIN_A) - t2_r;
  assign m3 = 33'(ta) * 33'(x4_r);
  always_comb begin
    sm = (m3[32:15] > 18'd32767) ? 16'd32767 : m3[30:15];
    s = q4_r[1] ? -$signed({1'b0, sm}) : $signed({1'b0, sm});
  end
endmodule
`default_nettype wire

@@ rtl/core/uvs_cell.sv @@
`default_nettype none
// One cell of the emission chain: load a record or shift from upstream
module uvs_cell
  import uvs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  load,
  input  wire slot_t load_d,
  input  wire logic  shift,
  input  wire slot_t up_d,
  output slot_t      q
);
  slot_t q_r, q_nxt;
  always_comb begin
    q_nxt = q_r;
    if (load) q_nxt = load_d;
    else if (shift) q_nxt = up_d;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) q_r.vld <= 1'b0;
    else q_r.vld <= q_nxt.vld;
    q_r.rec <= q_nxt.rec;
  end
  assign q = q_r;
endmodule
`default_nettype wire

@@ rtl/core/uv_sphere_mesh_generator_top.sv @@
`default_nettype none
// Results leave cell 0 of the output chain one per cycle once a request has
// passed the divider, sine and product stages and loaded the chain.
// Busy stays high after each accepted request, whatever its result count, while
// the 4-cell chain drains; a new request is accepted once busy falls.
// Reset (rst_n low, synchronous): registers take their reset values and the
// pipeline and chain empty. Results cannot be stalled by the receiver.
module uv_sphere_mesh_generator_top
  import uvs_pkg::*;
#(
  parameter int MAX_SEGMENTS = 255,
  parameter int MAX_RINGS = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_req_t     in_req,
  output logic             out_strobe,
  output out_req_t         out_req,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int AB = ANGLE_BITS;
  localparam int PL = 10;  // stages from accept to chain load

  logic signed [15:0] cx_r, cy_r, cz_r;
  logic [14:0] rx_r, ry_r, rz_r;
  logic [7:0]  seg_r, rng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
      rx_r <= 15'd256; ry_r <= 15'd256; rz_r <= 15'd256;
      seg_r <= 8'd16; rng_r <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: cx_r <= cfg_data;
        CFG_CENTER_Y: cy_r <= cfg_data;
        CFG_CENTER_Z: cz_r <= cfg_data;
        CFG_RADIUS_X: rx_r <= cfg_data[14:0];
        CFG_RADIUS_Y: ry_r <= cfg_data[14:0];
        CFG_RADIUS_Z: rz_r <= cfg_data[14:0];
        CFG_SEGMENTS: seg_r <= cfg_data[7:0];
        CFG_RINGS:    rng_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0] m, n;
  assign m = (32'(seg_r) > MAX_SEGMENTS) ? 8'(MAX_SEGMENTS) : seg_r;
  assign n = (32'(rng_r) > MAX_RINGS) ? 8'(MAX_RINGS) : rng_r;

  // busy window counter
  logic [2:0] bcnt_r;
  logic acc;
  assign busy = (bcnt_r != 3'd0);
  assign acc = start && !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) bcnt_r <= '0;
    else if (acc) bcnt_r <= 3'd3;
    else if (bcnt_r != 3'd0) bcnt_r <= bcnt_r - 3'd1;
  end

  // Stage 0: angles. Divide by n+1 and by m with two restoring dividers,
  // BPS steps a cycle until both quotients are complete.
  logic [PL-1:0] v_r;
  in_req_t rq_r [PL];
  logic ok0;
  always_comb begin
    ok0 = (m != 0) && (n != 0) && (in_req.segment < m);
    if (in_req.op == OP_GRID && in_req.ring >= n) ok0 = 1'b0;
  end

  // Phase numerators and iterative division (BPS quotient bits per pass)
  localparam int NW = AB + 8;
  logic [NW-1:0] nth_r, nal_r, rth_r, ral_r;
  logic [AB-1:0] qth_r, qal_r;
  logic [8:0] dth;
  logic [7:0] dal;
  assign dth = 9'(n) + 9'd1;
  assign dal = m;
  logic [2:0] dcnt_r;
  localparam int BPS = (AB + 3) / 4;

  always_ff @(posedge clk) begin
    if (!rst_n) dcnt_r <= 3'd3;
    else if (acc) dcnt_r <= 3'd0;
    else if (dcnt_r < 3'd3) dcnt_r <= dcnt_r + 3'd1;
  end

  // Seed the remainder with the numerator's top NW-AB bits: they lie below
  // the divisor, so the quotient fits AB bits and AB steps remain.
  always_ff @(posedge clk) begin
    logic [NW-1:0] rt, ra;
    logic [AB-1:0] qt, qa;
    logic [NW-1:0] nt, na;
    rt = rth_r; ra = ral_r; qt = qth_r; qa = qal_r; nt = nth_r; na = nal_r;
    if (acc) begin
      nt = NW'((32'(in_req.ring) + 1) << (AB - 1));
      na = NW'(32'(in_req.segment) << AB);
      rt = nt >> AB; ra = na >> AB;
      nt = nt << (NW - AB); na = na << (NW - AB);
      qt = '0; qa = '0;
    end
    if (acc || dcnt_r < 3'd3) begin
      for (int k = 0; k < BPS; k++) begin
        rt = {rt[NW-2:0], nt[NW-1]}; nt = {nt[NW-2:0], 1'b0};
        qt = {qt[AB-2:0], 1'b0};
        if (rt >= NW'(dth)) begin rt = rt - NW'(dth); qt[0] = 1'b1; end
        ra = {ra[NW-2:0], na[NW-1]}; na = {na[NW-2:0], 1'b0};
        qa = {qa[AB-2:0], 1'b0};
        if (ra >= NW'(dal)) begin ra = ra - NW'(dal); qa[0] = 1'b1; end
      end
    end
    rth_r <= rt; ral_r <= ra; qth_r <= qt; qal_r <= qa; nth_r <= nt; nal_r <= na;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[PL-2:0], acc && ok0};
    rq_r[0] <= in_req;
    for (int k = 1; k < PL; k++) rq_r[k] <= rq_r[k-1];
  end

  // Stage 4: trig phases (quotients complete after four division passes)
  logic [AB-1:0] th, al;
  assign th = qth_r - AB'(1 << (AB - 2));
  assign al = qal_r;
  logic signed [16:0] ct, st, ca, sa;
  uvs_sin u_ct (.clk(clk), .ph(th + AB'(1 << (AB-2))), .s(ct));
  uvs_sin u_st (.clk(clk), .ph(th), .s(st));
  uvs_sin u_ca (.clk(clk), .ph(al + AB'(1 << (AB-2))), .s(ca));
  uvs_sin u_sa (.clk(clk), .ph(al), .s(sa));

  // Stage 8 after sines: products r*|a|, then *|b| for x and z
  logic [31:0] px_r, pz_r;
  logic [31:0] py_r;
  logic [16:0] cam_r, sam_r;
  logic nx_r, nz_r, ny_r;
  logic [16:0] act, ast, aca, asa;
  assign act = ct[16] ? 17'(-ct) : 17'(ct);
  assign ast = st[16] ? 17'(-st) : 17'(st);
  assign aca = ca[16] ? 17'(-ca) : 17'(ca);
  assign asa = sa[16] ? 17'(-sa) : 17'(sa);
  always_ff @(posedge clk) begin
    px_r <= 32'(rx_r) * 32'(act);
    pz_r <= 32'(rz_r) * 32'(act);
    py_r <= 32'(ry_r) * 32'(ast);
    cam_r <= aca; sam_r <= asa;
    nx_r <= ct[16] ^ ca[16];
    nz_r <= ct[16] ^ sa[16];
    ny_r <= st[16];
  end
  logic [48:0] mx, mz;
  assign mx = 49'(px_r) * 49'(cam_r);
  assign mz = 49'(pz_r) * 49'(sam_r);
  logic signed [COORD_BITS+2:0] tx_r, ty_r, tz_r;
  always_ff @(posedge clk) begin
    logic [48:0] qx, qz, qy;
    qx = (mx + 49'(1 << 29)) >> 30;
    qz = (mz + 49'(1 << 29)) >> 30;
    qy = ({17'd0, py_r} * 49'd32768 + 49'(1 << 29)) >> 30;
    tx_r <= nx_r ? -$signed((COORD_BITS+3)'(qx)) : $signed((COORD_BITS+3)'(qx));
    tz_r <= nz_r ? -$signed((COORD_BITS+3)'(qz)) : $signed((COORD_BITS+3)'(qz));
    ty_r <= ny_r ? -$signed((COORD_BITS+3)'(qy)) : $signed((COORD_BITS+3)'(qy));
  end

  function automatic logic signed [COORD_BITS:0] sat(input logic signed [COORD_BITS+3:0] v);
    logic signed [COORD_BITS+3:0] hi, lo;
    hi = (COORD_BITS+4)'((64'sd1 <<< (COORD_BITS-1)) - 1);
    lo = -hi - 1;
    if (v > hi) return (COORD_BITS+1)'(hi);
    if (v < lo) return (COORD_BITS+1)'(lo);
    return (COORD_BITS+1)'(v);
  endfunction

  function automatic out_req_t mk_vtx(input logic [16:0] sl,
      input logic signed [COORD_BITS+3:0] x, input logic signed [COORD_BITS+3:0] y,
      input logic signed [COORD_BITS+3:0] z, input logic signed [15:0] ccx,
      input logic signed [15:0] ccy, input logic signed [15:0] ccz);
    out_req_t r;
    logic signed [COORD_BITS:0] sx, sy, sz;
    r = '0;
    sx = sat(x); sy = sat(y); sz = sat(z);
    r.kind = KIND_VERTEX; r.slot = sl;
    r.pos_x = 16'(sx); r.pos_y = 16'(sy); r.pos_z = 16'(sz);
    r.norm_x = 16'(sat((COORD_BITS+4)'(sx) - (COORD_BITS+4)'(ccx)));
    r.norm_y = 16'(sat((COORD_BITS+4)'(sy) - (COORD_BITS+4)'(ccy)));
    r.norm_z = 16'(sat((COORD_BITS+4)'(sz) - (COORD_BITS+4)'(ccz)));
    return r;
  endfunction

  function automatic out_req_t mk_tri(input logic [16:0] sl, input logic [15:0] a,
      input logic [15:0] b, input logic [15:0] c);
    out_req_t r;
    r = '0;
    r.kind = KIND_TRI; r.slot = sl;
    r.corner_a = a; r.corner_b = b; r.corner_c = c;
    return r;
  endfunction

  // Build up to four records at the chain load point
  in_req_t q;
  assign q = rq_r[PL-1];
  slot_t ld [4];
  always_comb begin
    logic [7:0] inx;
    logic [16:0] pm, pm1, np, face, fn;
    slot_t lst [4];
    int k;
    inx = (q.segment + 8'd1 == m) ? 8'd0 : q.segment + 8'd1;
    pm  = 17'(q.ring) * 17'(m);
    pm1 = pm + 17'(m);
    np  = 17'(n) * 17'(m) + 17'd1;
    face = 17'(m) + (pm << 1) + 17'({q.segment, 1'b0});
    fn = ((17'(n) * 17'(m)) << 1) - 17'd1 - 17'(q.segment);
    for (int j = 0; j < 4; j++) lst[j] = '0;
    k = 0;
    if (q.op == OP_GRID) begin
      lst[0].vld = 1'b1;
      lst[0].rec = mk_vtx(pm + 17'(q.segment) + 17'd1,
          (COORD_BITS+4)'(cx_r) + (COORD_BITS+4)'(tx_r),
          (COORD_BITS+4)'(cy_r) + (COORD_BITS+4)'(ty_r),
          (COORD_BITS+4)'(cz_r) + (COORD_BITS+4)'(tz_r), cx_r, cy_r, cz_r);
      k = 1;
      if (9'(q.ring) + 9'd1 < 9'(n)) begin
        lst[1].vld = 1'b1;
        lst[1].rec = mk_tri(face, 16'(pm + 17'(q.segment) + 1),
            16'(pm1 + 17'(q.segment) + 1), 16'(pm1 + 17'(inx) + 1));
        lst[2].vld = 1'b1;
        lst[2].rec = mk_tri(face + 17'd1, 16'(pm + 17'(q.segment) + 1),
            16'(pm1 + 17'(inx) + 1), 16'(pm + 17'(inx) + 1));
        k = 3;
      end
    end else begin
      if (q.segment == 8'd0) begin
        lst[0].vld = 1'b1;
        lst[0].rec = mk_vtx(17'd0, (COORD_BITS+4)'(cx_r),
            (COORD_BITS+4)'(cy_r) - (COORD_BITS+4)'(ry_r), (COORD_BITS+4)'(cz_r),
            cx_r, cy_r, cz_r);
        lst[1].vld = 1'b1;
        lst[1].rec = mk_vtx(np, (COORD_BITS+4)'(cx_r),
            (COORD_BITS+4)'(cy_r) + (COORD_BITS+4)'(ry_r), (COORD_BITS+4)'(cz_r),
            cx_r, cy_r, cz_r);
        k = 2;
      end
      lst[k].vld = 1'b1;
      lst[k].rec = mk_tri(17'(q.segment), 16'd0, 16'(q.segment) + 16'd1,
          16'(inx) + 16'd1);
      lst[k+1].vld = 1'b1;
      lst[k+1].rec = mk_tri(fn, 16'(np), 16'(np - 17'd1 - 17'(q.segment)),
          16'(np - 17'd1 - 17'(inx)));
      k = k + 2;
    end
    lst[k-1].rec.last = 1'b1;
    for (int j = 0; j < 4; j++) ld[j] = lst[j];
  end

  // Output chain of cells: cell 0 presents, others shift toward it
  slot_t cq [5];
  assign cq[4] = '0;
  for (genvar g = 0; g < 4; g++) begin : g_cell
    uvs_cell u_cell (
      .clk(clk), .rst_n(rst_n), .load(v_r[PL-1]), .load_d(ld[g]),
      .shift(1'b1), .up_d(cq[g+1]), .q(cq[g])
    );
  end

  assign out_strobe = cq[0].vld;
  assign out_req = cq[0].rec;
endmodule
`default_nettype wire
